FILE: hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants for the periodic command scheduler.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int unsigned MAX_ENTRIES = 3;
   localparam int unsigned TICK_W      = 32;
   localparam int unsigned IVL_W       = 16;
   localparam int unsigned GAP_W       = 8;
   localparam int unsigned IDX_W       = 2;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [TICK_W-1:0] WRAP_LIMIT = 32'h7fff_ffff;

   // reset values of the configuration registers
   localparam logic                   RST_READY   = 1'b0;
   localparam logic [MAX_ENTRIES-1:0] RST_ENABLE  = 3'b001;
   localparam logic [IVL_W-1:0]       RST_IVL_A   = 16'd40;
   localparam logic [IVL_W-1:0]       RST_IVL_B   = 16'd20;
   localparam logic [IVL_W-1:0]       RST_IVL_C   = 16'd10000;
   localparam logic [GAP_W-1:0]       RST_MIN_GAP = 8'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCHED_READY = 3'd0,
      CSR_ENABLE_MASK = 3'd1,
      CSR_INTERVAL_A  = 3'd2,
      CSR_INTERVAL_B  = 3'd3,
      CSR_INTERVAL_C  = 3'd4,
      CSR_MIN_GAP     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                              sched_ready;
      logic [MAX_ENTRIES-1:0]            enable_mask;
      logic [MAX_ENTRIES-1:0][IVL_W-1:0] interval;
      logic [GAP_W-1:0]                  min_gap;
   } cfg_type;

   typedef struct packed {
      logic             fired;
      logic [IDX_W-1:0] entry_index;
   } decision_type;

endpackage

FILE: hw/rtl/pcs_csr.sv
// ----------------------------------------------------------------------------
// pcs_csr
// Configuration registers of the scheduler, written through a plain port.
// ----------------------------------------------------------------------------
module pcs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output pcs_pkg::cfg_type                   cfg
);
   import pcs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SCHED_READY: cfg_in.sched_ready = csr_wdata[0];
            CSR_ENABLE_MASK: cfg_in.enable_mask = csr_wdata[MAX_ENTRIES-1:0];
            CSR_INTERVAL_A:  cfg_in.interval[0] = csr_wdata[IVL_W-1:0];
            CSR_INTERVAL_B:  cfg_in.interval[1] = csr_wdata[IVL_W-1:0];
            CSR_INTERVAL_C:  cfg_in.interval[2] = csr_wdata[IVL_W-1:0];
            CSR_MIN_GAP:     cfg_in.min_gap     = csr_wdata[GAP_W-1:0];
            default:         cfg_in = cfg_ff;   // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sched_ready <= RST_READY;
         cfg_ff.enable_mask <= RST_ENABLE;
         cfg_ff.interval[0] <= RST_IVL_A;
         cfg_ff.interval[1] <= RST_IVL_B;
         cfg_ff.interval[2] <= RST_IVL_C;
         cfg_ff.min_gap     <= RST_MIN_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/pcs_core.sv
// ----------------------------------------------------------------------------
// pcs_core
// Due-time and last-send state, wrap-safe eligibility tests, priority pick.
// ----------------------------------------------------------------------------
module pcs_core #(
   parameter int unsigned ENTRIES = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pcs_pkg::cfg_type               cfg,
   input  logic [pcs_pkg::TICK_W-1:0]     tick,
   input  logic                           advance,
   output pcs_pkg::decision_type          decision
);
   import pcs_pkg::*;

   logic [ENTRIES-1:0][TICK_W-1:0] due_ff, due_in;
   logic [TICK_W-1:0]              last_ff, last_in;
   logic [ENTRIES-1:0]             eligible;
   logic [TICK_W-1:0]              gap;
   logic                           gap_ok;
   decision_type                   pick;

   assign gap    = tick - last_ff;
   assign gap_ok = (gap > TICK_W'(cfg.min_gap)) && (gap < WRAP_LIMIT);

   always_comb begin
      logic [TICK_W-1:0] over;
      for (int k = 0; k < int'(ENTRIES); k++) begin
         over        = tick - due_ff[k];
         eligible[k] = cfg.enable_mask[k] && (over != '0) && (over < WRAP_LIMIT);
      end
   end

   // lowest-numbered eligible entry wins
   always_comb begin
      pick = '0;
      for (int k = int'(ENTRIES) - 1; k >= 0; k--) begin
         if (eligible[k]) begin
            pick.fired       = 1'b1;
            pick.entry_index = IDX_W'(k);
         end
      end
      if (!(cfg.sched_ready && gap_ok)) begin
         pick = '0;
      end
   end

   always_comb begin
      due_in  = due_ff;
      last_in = last_ff;
      if (advance && pick.fired) begin
         for (int k = 0; k < int'(ENTRIES); k++) begin
            if (pick.entry_index == IDX_W'(k)) begin
               due_in[k] = tick + TICK_W'(cfg.interval[k]);
            end
         end
         last_in = tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         due_ff  <= '0;
         last_ff <= '0;
      end else begin
         due_ff  <= due_in;
         last_ff <= last_in;
      end
   end

   assign decision = pick;

endmodule

FILE: hw/rtl/periodic_command_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_command_scheduler
// Picks at most one periodic command entry to fire on each tick item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   req     | in        | req_valid / req_stall  | req_tick_now[31:0]
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_fired, rsp_entry_index
//   csr     | in        | csr_wr_en              | csr_index, csr_wdata
//
// An item passes through the input register and then the result register,
// one item per cycle sustained while rsp is not stalled. The decision,
// the due-time reload and the last-send update all happen as the item moves
// from the input register to the result register, so the next item already
// sees the updated state. Reset (synchronous) empties both registers, clears
// all due times and the last-send tick, and loads the register defaults.
// A stall on rsp holds the result; req stalls only when the input register
// is full and cannot advance.
// ----------------------------------------------------------------------------
module periodic_command_scheduler #(
   parameter int unsigned ENTRIES = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [31:0]                        req_tick_now,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_fired,
   output logic [1:0]                         rsp_entry_index,
   input  logic                               csr_wr_en,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pcs_pkg::*;

   cfg_type           cfg;
   decision_type      decision;
   logic              in_valid_ff, in_valid_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              out_valid_ff, out_valid_in;
   decision_type      out_ff, out_in;
   logic              advance;

   pcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcs_core #(.ENTRIES(ENTRIES)) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .tick     (tick_ff),
      .advance  (advance),
      .decision (decision)
   );

   // move the held item on whenever the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      tick_in     = tick_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         tick_in     = req_tick_now;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = decision;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;   // result taken, nothing behind it
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
      out_ff  <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_fired       = out_ff.fired;
   assign rsp_entry_index = out_ff.entry_index;

endmodule

FILE: hw/rtl/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the periodic command scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pcs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [31:0]                        req_tick_now,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_fired,
   input logic [1:0]                         rsp_entry_index,
   input logic                               csr_wr_en,
   input logic [pcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [pcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pcs_pkg::*;

   // a result with nothing fired reports entry zero
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_entry_index == '0)
      else $error("no-fire result carries a nonzero entry index");

   // only three entries exist
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_index != 2'd3)
      else $error("entry index out of range");

   // reset empties the result register; check at the first edge out of reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_fired) && $stable(rsp_entry_index))
      else $error("stalled result changed");

endmodule

bind periodic_command_scheduler pcs_checker u_pcs_checker (.*);
